// File: sv/wtv_pkg.sv
// Shared types, constants and helpers of the windowed threshold veto.
// No dependencies; wtv_index, wtv_veto and the top level import this package.
package wtv_pkg;

  localparam int STORE_DEPTH = 1 << 20;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_EVENT = 1'b1;

  // time index: floor((ns + 1) * rate / 1e9) by reciprocal multiplication
  localparam logic [29:0] NS_PER_S = 30'd1000000000;
  // floor(2^61 / 1e9), applied to the top 32 bits of a 47-bit dividend
  localparam logic [31:0] NS_RECIP = 32'd2305843009;

  typedef enum logic [2:0] {
    REG_THRESHOLD   = 3'd0,
    REG_WINDOW      = 3'd1,
    REG_RATE        = 3'd2,
    REG_SEG_START   = 3'd3,
    REG_TIME_LIMIT  = 3'd4,
    REG_MAX_RATIO   = 3'd5,
    REG_POWER_COEFF = 3'd6,
    REG_POWER_EXP   = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic        [31:0] sample_threshold;
    logic        [19:0] window_samples;
    logic        [16:0] sample_rate_hz;
    logic        [30:0] segment_start_s;
    logic signed [21:0] time_limit_samples;
    logic signed [24:0] max_ratio;
    logic signed [31:0] power_coeff;
    logic signed [15:0] power_exponent;
  } cfg_regs_t;

  typedef struct packed {
    logic                oor;
    logic [STORE_AW-1:0] last;
    logic [STORE_AW-1:0] first;
  } idx_res_t;

  typedef struct packed {
    logic [20:0] count;
    logic [23:0] ratio;
  } veto_req_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_INDEX, ST_WALK, ST_DRAIN, ST_VSTART, ST_VETO, ST_FINISH
  } top_state_t;

  typedef enum logic [2:0] {
    IX_IDLE, IX_MUL, IX_DIV, IX_FIX, IX_SUM
  } idx_state_t;

  typedef enum logic [2:0] {
    VT_IDLE, VT_LOG, VT_MUL, VT_SCALE, VT_RATE, VT_ALIGN, VT_CMP
  } veto_state_t;

  // position of the leading one; zero input gives zero
  function automatic logic [4:0] msb_pos(input logic [23:0] v);
    logic [4:0] p;
    p = '0;
    for (int i = 0; i < 24; i++) begin
      if (v[i]) p = 5'(i);
    end
    return p;
  endfunction

endpackage

// File: sv/wtv_if.sv
// Channel interfaces of the windowed threshold veto: items, results, config.
// Depends on nothing; payload widths follow the block's field list.
interface wtv_item_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [19:0] sample_address;
  logic [31:0] sample_value;
  logic [30:0] event_seconds;
  logic [29:0] event_nanoseconds;
  logic [23:0] event_ratio;
  modport source (output valid, command, sample_address, sample_value,
                  event_seconds, event_nanoseconds, event_ratio, input ready);
  modport sink (input valid, command, sample_address, sample_value,
                event_seconds, event_nanoseconds, event_ratio, output ready);
endinterface

interface wtv_result_if;
  logic        valid;
  logic        ready;
  logic [20:0] samples_above;
  logic        vetoed;
  logic        out_of_range;
  modport source (output valid, samples_above, vetoed, out_of_range, input ready);
  modport sink (input valid, samples_above, vetoed, out_of_range, output ready);
endinterface

interface wtv_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  addr;
  logic [31:0] data;
  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

// File: sv/wtv_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module wtv_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);
  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: sv/wtv_index.sv
// Trigger time to sample index: two multipliers, then a reciprocal multiply for 1/1e9.
// Depends on wtv_pkg (cfg_regs_t, idx_res_t, NS_PER_S, NS_RECIP).
module wtv_index import wtv_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [30:0] event_seconds,
  input  logic [29:0] event_nanoseconds,
  input  cfg_regs_t   cfg,
  output logic        done,
  output idx_res_t    res
);
  idx_state_t state, state_next;

  logic signed [31:0]  diff;
  logic        [30:0]  nsp1;
  logic signed [49:0]  prod;
  logic        [46:0]  num;
  logic        [17:0]  q_est;
  logic        [18:0]  quo;
  logic        [63:0]  recip;
  logic        [47:0]  q_back;
  logic        [47:0]  rem;
  logic signed [50:0]  full;
  logic [STORE_AW-1:0] last;

  always_ff @(posedge clk) begin
    if (rst) state <= IX_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      IX_IDLE: if (start) state_next = IX_MUL;
      IX_MUL:  state_next = IX_DIV;
      IX_DIV:  state_next = IX_FIX;
      IX_FIX:  state_next = IX_SUM;
      IX_SUM:  state_next = IX_IDLE;
      default: state_next = IX_IDLE;
    endcase
  end

  // estimate never exceeds the true quotient and is short by at most one
  always_comb begin
    recip  = 64'(num[46:15]) * 64'(NS_RECIP);
    q_back = 48'(q_est) * 48'(NS_PER_S);
    rem    = 48'(num) - q_back;
  end

  always_ff @(posedge clk) begin
    case (state)
      IX_IDLE: begin
        diff <= $signed({1'b0, event_seconds}) - $signed({1'b0, cfg.segment_start_s});
        nsp1 <= {1'b0, event_nanoseconds} + 31'd1;
      end
      IX_MUL: begin
        prod <= diff * $signed({1'b0, cfg.sample_rate_hz});
        num  <= 47'(nsp1) * 47'(cfg.sample_rate_hz);
      end
      IX_DIV: q_est <= recip[63:46];
      IX_FIX: quo   <= {1'b0, q_est} + 19'(rem >= 48'(NS_PER_S));
      default: ;
    endcase
  end

  always_comb begin
    full     = 51'(prod) + $signed({32'b0, quo});
    last     = full[STORE_AW-1:0];
    done     = (state == IX_SUM);
    res.oor  = full[50] || (full[49:STORE_AW] != '0);
    res.last = last;
    res.first = (last > cfg.window_samples) ? last - cfg.window_samples : '0;
  end
endmodule

// File: sv/wtv_veto.sv
// Veto decision: time test and power-law bound via log2/exp2 approximation.
// Sequenced over several cycles, one multiplier per step. Depends on wtv_pkg.
module wtv_veto import wtv_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  veto_req_t req,
  input  cfg_regs_t cfg,
  output logic      done,
  output logic      vetoed
);
  veto_state_t state, state_next;

  logic        [20:0] cnt;
  logic        [23:0] rat;
  logic signed [20:0] lg;
  logic signed [36:0] prod;
  logic signed [8:0]  n;
  logic        [31:0] s;
  logic        [48:0] r;
  logic        [85:0] a, b;
  logic               a_big, b_big;

  logic [4:0]  e;
  logic [39:0] mant;
  logic [16:0] m;
  logic [47:0] cm;
  logic [36:0] lhs;
  logic [9:0]  k;
  logic tl_pos, mr_pos, c_pos, x_pos, time_hit, power_hit;

  always_ff @(posedge clk) begin
    if (rst) state <= VT_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      VT_IDLE:  if (start) state_next = VT_LOG;
      VT_LOG:   state_next = VT_MUL;
      VT_MUL:   state_next = VT_SCALE;
      VT_SCALE: state_next = VT_RATE;
      VT_RATE:  state_next = VT_ALIGN;
      VT_ALIGN: state_next = VT_CMP;
      VT_CMP:   state_next = VT_IDLE;
      default:  state_next = VT_IDLE;
    endcase
  end

  always_comb begin
    e    = msb_pos(rat);
    mant = {rat, 16'b0} >> e;
    m    = {1'b1, prod[27:12]};
    cm   = cfg.power_coeff[30:0] * m;
    lhs  = {cnt, 16'b0};
    k    = 10'd0 - {n[8], n};
  end

  always_ff @(posedge clk) begin
    case (state)
      VT_IDLE: begin
        cnt <= req.count;
        rat <= req.ratio;
      end
      VT_LOG:   lg <= {e - 5'd16, mant[15:0]};
      VT_MUL:   prod <= lg * cfg.power_exponent;
      VT_SCALE: begin
        n <= prod[36:28];
        s <= cm[47:16];
      end
      VT_RATE:  r <= cfg.sample_rate_hz * s;
      VT_ALIGN: begin
        if (!n[8]) begin
          a     <= {49'b0, lhs};
          b     <= {37'b0, r} << n[5:0];
          b_big <= (r != '0) && (n >= 9'sd37);
          a_big <= 1'b0;
        end else begin
          a     <= {49'b0, lhs} << k[5:0];
          b     <= {37'b0, r};
          a_big <= (lhs != '0) && (k >= 10'd49);
          b_big <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    tl_pos    = !cfg.time_limit_samples[21] && (cfg.time_limit_samples != '0);
    mr_pos    = !cfg.max_ratio[24] && (cfg.max_ratio != '0);
    c_pos     = !cfg.power_coeff[31] && (cfg.power_coeff != '0);
    x_pos     = !cfg.power_exponent[15] && (cfg.power_exponent != '0);
    time_hit  = ($signed({1'b0, rat}) < cfg.max_ratio) &&
                ($signed({1'b0, cnt}) > cfg.time_limit_samples);
    power_hit = (rat == '0) ? (cnt != '0) : (a_big || (!b_big && (a > b)));
    done      = (state == VT_CMP);
    vetoed    = 1'b0;
    if (tl_pos && mr_pos && (cfg.power_coeff[31] || cfg.power_exponent[15]))
      vetoed = time_hit;
    else if (tl_pos && mr_pos && c_pos && x_pos)
      vetoed = time_hit || power_hit;
  end
endmodule

// File: sv/windowed_threshold_veto.sv
// Windowed threshold veto, top level: register file, window walk and result stage.
// Depends on wtv_pkg, wtv_if, wtv_ram, wtv_index and wtv_veto.
//
// Usage. The items channel carries two kinds of item. A load item (command 0)
// writes sample_value into the sample store at sample_address; it is taken while
// the block is idle and gives no result. An event item (command 1) gives a trigger
// time and ratio; it yields one result with the count of window samples at or
// above the threshold, the veto flag and the out-of-range flag.
// An event passes through the sample index (two multipliers, then a reciprocal
// multiply for the divide by 1e9 and one correction), the store reads of the
// window (window_samples + 1 at most), drain, veto and result load; the block
// is ready for the next item as soon as the result is valid. An out-of-range
// index skips walk and veto. Items are processed one at a time.
// The result sits in an output register: the next item is taken while it
// waits, and a second event stalls before its result is written until the
// receiver has taken the first. Configuration is taken at any time, one write
// per cycle; it should be changed only while the block is idle.
// Reset restores register defaults and clears all control; the store contents
// are undefined until written.
module windowed_threshold_veto import wtv_pkg::*; (
  input logic          clk,
  input logic          rst,
  wtv_item_if.sink     items,
  wtv_result_if.source results,
  wtv_cfg_if.sink      cfg
);
  top_state_t state, state_next;
  cfg_regs_t  regs;

  logic                idx_start, idx_done;
  idx_res_t            idx_res;
  logic                veto_start, veto_done, veto_flag;
  veto_req_t           veto_req;
  logic                accept, ram_we, load_res;
  logic [31:0]         rdata;
  logic [STORE_AW-1:0] walk_x, idx_end;
  logic                rd_pend, oor_q, veto_q;
  logic [20:0]         count;
  logic [23:0]         ratio_q;
  logic                res_valid, res_veto, res_oor;
  logic [20:0]         res_count;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.sample_threshold   <= '0;
      regs.window_samples     <= '0;
      regs.sample_rate_hz     <= 17'd4096;
      regs.segment_start_s    <= '0;
      regs.time_limit_samples <= '1;
      regs.max_ratio          <= '1;
      regs.power_coeff        <= '1;
      regs.power_exponent     <= '1;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.addr))
        REG_THRESHOLD:   regs.sample_threshold   <= cfg.data;
        REG_WINDOW:      regs.window_samples     <= cfg.data[19:0];
        REG_RATE:        regs.sample_rate_hz     <= cfg.data[16:0];
        REG_SEG_START:   regs.segment_start_s    <= cfg.data[30:0];
        REG_TIME_LIMIT:  regs.time_limit_samples <= cfg.data[21:0];
        REG_MAX_RATIO:   regs.max_ratio          <= cfg.data[24:0];
        REG_POWER_COEFF: regs.power_coeff        <= cfg.data;
        REG_POWER_EXP:   regs.power_exponent     <= cfg.data[15:0];
      endcase
    end
  end

  wtv_ram #(.W(32), .DEPTH(STORE_DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (items.sample_address[STORE_AW-1:0]),
    .wdata (items.sample_value),
    .raddr (walk_x),
    .rdata (rdata)
  );

  wtv_index u_index (
    .clk               (clk),
    .rst               (rst),
    .start             (idx_start),
    .event_seconds     (items.event_seconds),
    .event_nanoseconds (items.event_nanoseconds),
    .cfg               (regs),
    .done              (idx_done),
    .res               (idx_res)
  );

  assign veto_req.count = count;
  assign veto_req.ratio = ratio_q;

  wtv_veto u_veto (
    .clk    (clk),
    .rst    (rst),
    .start  (veto_start),
    .req    (veto_req),
    .cfg    (regs),
    .done   (veto_done),
    .vetoed (veto_flag)
  );

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (items.valid && items.command == CMD_EVENT) state_next = ST_INDEX;
      ST_INDEX:  if (idx_done) state_next = idx_res.oor ? ST_FINISH : ST_WALK;
      ST_WALK:   if (walk_x == idx_end) state_next = ST_DRAIN;
      ST_DRAIN:  state_next = ST_VSTART;
      ST_VSTART: state_next = ST_VETO;
      ST_VETO:   if (veto_done) state_next = ST_FINISH;
      ST_FINISH: if (!res_valid || results.ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    items.ready = (state == ST_IDLE);
    accept      = items.valid && items.ready;
    ram_we      = accept && (items.command == CMD_LOAD);
    idx_start   = accept && (items.command == CMD_EVENT);
    veto_start  = (state == ST_VSTART);
    load_res    = (state == ST_FINISH) && (!res_valid || results.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) rd_pend <= 1'b0;
    else     rd_pend <= (state == ST_WALK);
  end

  always_ff @(posedge clk) begin
    if (idx_start) ratio_q <= items.event_ratio;
    if (state == ST_INDEX && idx_done) begin
      walk_x  <= idx_res.first;
      idx_end <= idx_res.last;
      oor_q   <= idx_res.oor;
      count   <= '0;
      veto_q  <= 1'b0;
    end else begin
      if (state == ST_WALK) walk_x <= walk_x + 1'b1;
      // read data arrives the cycle after its address
      if (rd_pend && rdata >= regs.sample_threshold) count <= count + 1'b1;
      if (state == ST_VETO && veto_done) veto_q <= veto_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_res) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      res_count <= oor_q ? '0 : count;
      res_veto  <= oor_q ? 1'b0 : veto_q;
      res_oor   <= oor_q;
    end
  end

  assign results.valid         = res_valid;
  assign results.samples_above = res_count;
  assign results.vetoed        = res_veto;
  assign results.out_of_range  = res_oor;

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_WALK |-> walk_x <= idx_end)
    else $error("walk address past window end");

  a_read_origin: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> $past(state) == ST_WALK)
    else $error("store read counted outside the walk");

  a_veto_finish: assert property (@(posedge clk) disable iff (rst)
    (state == ST_VETO && veto_done) |=> state == ST_FINISH)
    else $error("veto completion lost");

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> state == ST_IDLE && !rd_pend)
    else $error("store write during a walk");
endmodule
